/* design/malu_pkg.sv */
// Package for the monomial ALU: command codes and the front-to-back queue entry type.
// Depends on nothing.
`default_nettype none
package malu_pkg;
  localparam logic [1:0] CMD_MUL = 2'd0;
  localparam logic [1:0] CMD_GCD = 2'd1;
  localparam logic [1:0] CMD_LCM = 2'd2;
  localparam logic [1:0] CMD_EQ  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        zero;
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] exps;
    logic        eovf;
    logic        eq;
  } malu_job_t;
endpackage
`default_nettype wire

/* design/monomial_alu.sv */
// Monomial ALU: multiply, gcd, lcm and compare on two monomials.
// The coefficient unit is sequential: shift-add multiply and restoring divide work one bit per
// cycle, and gcd and lcm use a binary gcd (lcm adds a divide and a multiply).
// One beat is worked at a time; a two-entry queue parts the front from the coefficient unit.
// Reset (rst_n, synchronous) empties the queue and sets the coefficient unit idle, so empty is high.
`default_nettype none
module monomial_alu #(
  parameter int NUM_VARS  = 8,
  parameter int EXP_BITS  = 8,
  parameter int COEF_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_coef_a,
  input  wire logic [63:0] in_exps_a,
  input  wire logic [31:0] in_coef_b,
  input  wire logic [63:0] in_exps_b,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_coef_out,
  output logic [63:0]      out_exps_out,
  output logic             out_is_equal,
  output logic             out_overflow
);
  import malu_pkg::*;

  malu_job_t fj;
  malu_job_t q_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic busy, done, start;

  malu_front #(.NUM_VARS(NUM_VARS), .EXP_BITS(EXP_BITS), .COEF_BITS(COEF_BITS)) u_front (
    .cmd(in_command), .coef_a(in_coef_a), .exps_a(in_exps_a),
    .coef_b(in_coef_b), .exps_b(in_exps_b), .job(fj));

  assign full = (cnt_r == 2'd2);
  assign start = (cnt_r != 2'd0) && !busy;
  assign empty = !done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push && !full) begin
        q_r[wr_r] <= fj;
        wr_r <= ~wr_r;
      end
      if (start) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'(start ? 1 : 0);
    end
  end

  malu_back #(.COEF_BITS(COEF_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .start(start), .job(q_r[rd_r]), .busy(busy), .done(done),
    .coef_out(out_coef_out), .exps_out(out_exps_out), .is_equal(out_is_equal),
    .overflow(out_overflow), .take(pop));
endmodule
`default_nettype wire

/* design/malu_front.sv */
// Front part: accepts a beat, classifies it and does the exponent-wise work.
// Depends on malu_pkg.
`default_nettype none
module malu_front #(
  parameter int NUM_VARS  = 8,
  parameter int EXP_BITS  = 8,
  parameter int COEF_BITS = 32
) (
  input  wire logic              [1:0]  cmd,
  input  wire logic              [31:0] coef_a,
  input  wire logic              [63:0] exps_a,
  input  wire logic              [31:0] coef_b,
  input  wire logic              [63:0] exps_b,
  output malu_pkg::malu_job_t           job
);
  import malu_pkg::*;

  localparam int NF = (NUM_VARS < 64 / EXP_BITS) ? NUM_VARS : 64 / EXP_BITS;

  logic [COEF_BITS-1:0] ca, cb;
  logic [31:0] sa, sb;
  logic [EXP_BITS-1:0] x, y, r;
  logic [EXP_BITS:0] s;
  logic za, zb, ovf, same;
  logic [63:0] e;

  always_comb begin
    ca = coef_a[COEF_BITS-1:0];
    cb = coef_b[COEF_BITS-1:0];
    sa = 32'(signed'(ca));
    sb = 32'(signed'(cb));
    za = (ca == '0);
    zb = (cb == '0);
    e = '0;
    ovf = 1'b0;
    same = (ca == cb);
    for (int i = 0; i < NF; i++) begin
      x = exps_a[i*EXP_BITS +: EXP_BITS];
      y = exps_b[i*EXP_BITS +: EXP_BITS];
      s = {1'b0, x} + {1'b0, y};
      if (x != y) same = 1'b0;
      case (cmd)
        CMD_MUL: begin
          r = s[EXP_BITS-1:0];
          if (s[EXP_BITS]) ovf = 1'b1;
        end
        CMD_GCD: r = (x < y) ? x : y;
        default: r = (x > y) ? x : y;
      endcase
      e[i*EXP_BITS +: EXP_BITS] = r;
    end
    job.cmd  = cmd;
    job.zero = za | zb;
    job.neg  = sa[31] ^ sb[31];
    job.ma   = sa[31] ? 32'(-sa) : sa;
    job.mb   = sb[31] ? 32'(-sb) : sb;
    job.exps = e;
    job.eovf = ovf;
    job.eq   = (za | zb) ? (za & zb) : same;
  end
endmodule
`default_nettype wire

/* design/malu_back.sv */
// Back part: sequential coefficient unit (shift-add multiply, binary gcd, restoring divide).
// Depends on malu_pkg.
`default_nettype none
module malu_back #(
  parameter int COEF_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  malu_pkg::malu_job_t        job,
  output logic                       busy,
  output logic                       done,
  output logic [31:0]                coef_out,
  output logic [63:0]                exps_out,
  output logic                       is_equal,
  output logic                       overflow,
  input  wire logic                  take
);
  import malu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LMUL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] st_r;
  malu_job_t j_r;
  logic [63:0] acc_r, mc_r;
  logic [31:0] u_r, v_r, q_r, rem_r;
  logic [5:0] k_r, cnt_r;
  logic [63:0] res;
  logic [32:0] trial;
  logic [63:0] sp;
  logic [63:0] lim;
  logic [COEF_BITS-1:0] cb;

  assign busy = (st_r != S_IDLE);
  assign done = (st_r == S_OUT);
  assign trial = {rem_r, q_r[31]} - {1'b0, j_r.ma == 0 ? 32'd1 : u_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (start) begin
          j_r <= job;
          u_r <= job.ma;
          v_r <= job.mb;
          k_r <= '0;
          acc_r <= '0;
          mc_r <= {32'd0, job.ma};
          cnt_r <= '0;
          if (job.cmd == CMD_EQ || job.zero) st_r <= S_FIN;
          else if (job.cmd == CMD_MUL) st_r <= S_MUL;
          else st_r <= S_GCD;
        end
        S_MUL: begin
          if (v_r[0]) acc_r <= acc_r + mc_r;
          mc_r <= mc_r << 1;
          v_r <= v_r >> 1;
          if (v_r[31:1] == 0) st_r <= S_FIN;
        end
        S_GCD: begin
          if (u_r == v_r) begin
            u_r <= u_r << k_r;
            if (j_r.cmd == CMD_GCD) begin
              acc_r <= {32'd0, u_r << k_r};
              j_r.neg <= 1'b0;
              st_r <= S_FIN;
            end else begin
              q_r <= j_r.ma;
              rem_r <= '0;
              cnt_r <= '0;
              st_r <= S_DIV;
            end
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + 6'd1;
          end else if (!u_r[0]) u_r <= u_r >> 1;
          else if (!v_r[0]) v_r <= v_r >> 1;
          else if (u_r > v_r) u_r <= (u_r - v_r) >> 1;
          else v_r <= (v_r - u_r) >> 1;
        end
        S_DIV: begin
          if (!trial[32]) begin
            rem_r <= trial[31:0];
            q_r <= {q_r[30:0], 1'b1};
          end else begin
            rem_r <= {rem_r[30:0], q_r[31]};
            q_r <= {q_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) st_r <= S_LMUL;
        end
        S_LMUL: begin
          mc_r <= {32'd0, q_r};
          v_r <= j_r.mb;
          acc_r <= '0;
          st_r <= S_MUL;
          j_r.neg <= 1'b0;
        end
        S_FIN: begin
          is_equal <= (j_r.cmd == CMD_EQ) & j_r.eq;
          if (j_r.cmd == CMD_EQ || j_r.zero) begin
            coef_out <= '0;
            exps_out <= '0;
            overflow <= 1'b0;
          end else begin
            coef_out <= 32'(signed'(cb));
            if (cb == '0) begin
              exps_out <= '0;
              overflow <= 1'b1;
            end else begin
              exps_out <= j_r.exps;
              overflow <= j_r.eovf | (j_r.neg ? (acc_r > lim) : (acc_r >= lim));
            end
          end
          st_r <= S_OUT;
        end
        S_OUT: if (take) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    sp = acc_r;
    res = j_r.neg ? 64'(-sp) : sp;
    cb = res[COEF_BITS-1:0];
    lim = 64'd1 << (COEF_BITS - 1);
  end
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for monomial_alu: directed and random monomial operations
// are predicted in the bench and compared beat by beat with the block's results.
// Depends on malu_pkg and monomial_alu.
`timescale 1ns / 1ps
module tb_top;
  import malu_pkg::*;

  localparam int NV = 8;
  localparam int EB = 8;
  localparam int CB = 32;
  localparam int WATCH_LIMIT = 4000;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] ca;
    logic [63:0] ea;
    logic [31:0] cb;
    logic [63:0] eb;
  } op_t;

  typedef struct {
    logic [31:0] coef;
    logic [63:0] exps;
    logic        eq;
    logic        ovf;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0]  in_command = '0;
  logic [31:0] in_coef_a = '0, in_coef_b = '0;
  logic [63:0] in_exps_a = '0, in_exps_b = '0;
  logic [31:0] out_coef_out;
  logic [63:0] out_exps_out;
  logic out_is_equal, out_overflow;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_wait = 0;
  int   take_wait = 0;
  bit   stim_done = 1'b0;
  bit   hold_send = 1'b0;

  monomial_alu i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_command(in_command), .in_coef_a(in_coef_a), .in_exps_a(in_exps_a),
    .in_coef_b(in_coef_b), .in_exps_b(in_exps_b),
    .empty(empty), .pop(pop), .out_coef_out(out_coef_out),
    .out_exps_out(out_exps_out), .out_is_equal(out_is_equal), .out_overflow(out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned magnitude(longint signed v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic res_t monomial_result(op_t op);
    res_t r;
    longint signed a, b, p;
    longint unsigned ma, mb, g, m, x, y, e;
    logic [31:0] cbits;
    r = '{coef: '0, exps: '0, eq: 1'b0, ovf: 1'b0};
    a = longint'($signed(op.ca));
    b = longint'($signed(op.cb));
    cbits = '0;
    if (op.cmd == CMD_EQ) begin
      if (a == 0 || b == 0) begin
        r.eq = (a == 0 && b == 0);
      end else begin
        r.eq = (a == b) && (op.ea == op.eb);
      end
    end else if (a != 0 && b != 0) begin
      if (op.cmd == CMD_MUL) begin
        p = a * b;
        if (p > 64'sd2147483647 || p < -64'sd2147483648) r.ovf = 1'b1;
        cbits = p[31:0];
      end else begin
        ma = magnitude(a);
        mb = magnitude(b);
        g = gcd_of(ma, mb);
        m = (op.cmd == CMD_GCD) ? g : (ma / g) * mb;
        if (m > 64'd2147483647) r.ovf = 1'b1;
        cbits = m[31:0];
      end
      for (int i = 0; i < NV; i++) begin
        x = op.ea[i*EB +: EB];
        y = op.eb[i*EB +: EB];
        if (op.cmd == CMD_MUL) begin
          e = x + y;
          if (e > 255) r.ovf = 1'b1;
        end else if (op.cmd == CMD_GCD) begin
          e = (x < y) ? x : y;
        end else begin
          e = (x > y) ? x : y;
        end
        r.exps[i*EB +: EB] = e[EB-1:0];
      end
      if (cbits == 0) begin
        r.exps = '0;
        r.ovf = 1'b1;
      end
      r.coef = cbits;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'(int'($urandom_range(0, 20)) - 10);
      4: return 32'(1 << $urandom_range(0, 31));
      5: return 32'(int'($urandom_range(0, 2000)) - 1000) * 32'(1 << $urandom_range(0, 12));
      6: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_exps();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: v = v & 64'h0f0f_0f0f_0f0f_0f0f;
      1: v = 64'h0;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    op_t op;
    logic [1:0] c;
    for (int k = 0; k < 4; k++) begin
      c = 2'(k);
      pending_ops.push_back('{c, 32'h8000_0000, 64'hffff_ffff_ffff_ffff,
                              32'h8000_0000, 64'hffff_ffff_ffff_ffff});
      pending_ops.push_back('{c, 32'h7fff_ffff, 64'h0, 32'hffff_ffff, 64'h0102_0304_0506_0708});
      pending_ops.push_back('{c, 32'd0, 64'h1234, 32'd5, 64'h1234});
      pending_ops.push_back('{c, 32'd0, 64'h11, 32'd0, 64'h22});
      pending_ops.push_back('{c, 32'd65536, 64'h80ff_0001, 32'd65536, 64'h80ff_0001});
      pending_ops.push_back('{c, 32'hffff_ffce, 64'h0f00, 32'd12, 64'h00f0});
    end
    for (int k = 0; k < 1750; k++) begin
      op.cmd = 2'($urandom_range(0, 3));
      op.ca = pick_coef();
      op.ea = pick_exps();
      if (op.cmd == CMD_EQ && $urandom_range(0, 1)) begin
        op.cb = op.ca;
        op.eb = op.ea;
        if ($urandom_range(0, 2) == 0) op.eb[$urandom_range(0, 63)] ^= 1'b1;
        if ($urandom_range(0, 4) == 0) op.cb ^= 32'(1 << $urandom_range(0, 31));
      end else begin
        op.cb = pick_coef();
        op.eb = pick_exps();
      end
      pending_ops.push_back(op);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(monomial_result('{in_command, in_coef_a, in_exps_a,
                                                     in_coef_b, in_exps_b}));
        void'(pending_ops.pop_front());
        send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (pending_ops.size() == 1000) hold_send = 1'b1;
      end
      if (hold_send && expected_results.size() == 0 && !(push && !full)) hold_send = 1'b0;
      if (push && full) begin
        push <= 1'b1;
      end else if (pending_ops.size() == 0) begin
        push <= 1'b0;
        stim_done = 1'b1;
      end else if (hold_send || send_wait > 0) begin
        if (send_wait > 0) send_wait--;
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        in_command <= pending_ops[0].cmd;
        in_coef_a <= pending_ops[0].ca;
        in_exps_a <= pending_ops[0].ea;
        in_coef_b <= pending_ops[0].cb;
        in_exps_b <= pending_ops[0].eb;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_coef_out !== want.coef) begin
            $error("coef_out expected %h actual %h", want.coef, out_coef_out);
            errors++;
          end
          if (out_exps_out !== want.exps) begin
            $error("exps_out expected %h actual %h", want.exps, out_exps_out);
            errors++;
          end
          if (out_is_equal !== want.eq) begin
            $error("is_equal expected %b actual %b", want.eq, out_is_equal);
            errors++;
          end
          if (out_overflow !== want.ovf) begin
            $error("overflow expected %b actual %b", want.ovf, out_overflow);
            errors++;
          end
        end
        take_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (take_wait > 0) begin
        take_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (stim_done && expected_results.size() == 0) begin
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0) begin
          $display("SCOREBOARD CLEAN");
        end else begin
          $display("SCOREBOARD MISMATCH");
        end
        $finish;
      end
    end
  end
endmodule
